/* rtl/bank_switch_memory_decoder_macros.svh */
// ----------------------------------------------------------------------------
// Bank switch memory decoder assertion macros
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef BANK_SWITCH_MEMORY_DECODER_MACROS_SVH
`define BANK_SWITCH_MEMORY_DECODER_MACROS_SVH

// Same-cycle implication.
`define BSMD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BSMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/bsmd_pkg.sv */
// ----------------------------------------------------------------------------
// bsmd_pkg
// Types and constants of the bank switch memory decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bsmd_pkg;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    REG_RAM    = 4'd0,
    REG_BASIC  = 4'd1,
    REG_CHAR   = 4'd2,
    REG_KERNAL = 4'd3,
    REG_VIC    = 4'd4,
    REG_SID    = 4'd5,
    REG_COLOR  = 4'd6,
    REG_CIA1   = 4'd7,
    REG_CIA2   = 4'd8,
    REG_OPENIO = 4'd9,
    REG_TOGGLE = 4'd10
  } region_e;

  localparam logic [15:0] ADDR_PORT_DIR  = 16'h0000;
  localparam logic [15:0] ADDR_PORT_DATA = 16'h0001;
  localparam logic [15:0] ADDR_TOGGLE    = 16'hdfff;

  localparam logic [3:0] BANK_BASIC_LO  = 4'ha;
  localparam logic [3:0] BANK_BASIC_HI  = 4'hb;
  localparam logic [3:0] BANK_IO        = 4'hd;
  localparam logic [3:0] BANK_KERNAL_LO = 4'he;
  localparam logic [3:0] BANK_KERNAL_HI = 4'hf;

  localparam logic [3:0] SEL_VIC_LAST   = 4'h3;
  localparam logic [3:0] SEL_SID_LAST   = 4'h7;
  localparam logic [3:0] SEL_COLOR_LAST = 4'hb;
  localparam logic [3:0] SEL_CIA1       = 4'hc;
  localparam logic [3:0] SEL_CIA2       = 4'hd;

  localparam logic [15:0] MASK_ROM8K = 16'h1fff;
  localparam logic [15:0] MASK_4K    = 16'h0fff;
  localparam logic [15:0] MASK_COLOR = 16'h03ff;
  localparam logic [15:0] MASK_VIC   = 16'h003f;
  localparam logic [15:0] MASK_SID   = 16'h001f;
  localparam logic [15:0] MASK_CIA   = 16'h000f;

  localparam logic [7:0] SHADOW_MASK  = 8'h17;
  localparam logic [7:0] NIBBLE_MASK  = 8'h0f;
  localparam logic [7:0] TOGGLE_RESET = 8'h55;

  typedef struct packed {
    op_e         opcode;
    logic [15:0] address;
    logic [7:0]  write_data;
  } req_t;

  typedef struct packed {
    region_e     target_region;
    logic [15:0] target_offset;
    logic [7:0]  out_data;
    logic [7:0]  port_lines;
  } rsp_t;

  typedef struct packed {
    logic [7:0] dir;
    logic [7:0] data;
    logic [7:0] toggle;
  } port_state_t;

  typedef struct packed {
    logic       dir_we;
    logic       data_we;
    logic       toggle_flip;
    logic [7:0] wdata;
  } port_upd_t;

endpackage

`default_nettype wire

/* rtl/bsmd_req_if.sv */
// ----------------------------------------------------------------------------
// bsmd_req_if
// Request channel: one bus access, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bsmd_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] address;
  logic [7:0]  write_data;

  modport source (output valid, output opcode, output address, output write_data,
                  input ready);
  modport sink (input valid, input opcode, input address, input write_data,
                output ready);
endinterface

`default_nettype wire

/* rtl/bsmd_rsp_if.sv */
// ----------------------------------------------------------------------------
// bsmd_rsp_if
// Result channel: decoded target, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bsmd_rsp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  target_region;
  logic [15:0] target_offset;
  logic [7:0]  out_data;
  logic [7:0]  port_lines;

  modport source (output valid, output target_region, output target_offset,
                  output out_data, output port_lines, input ready);
  modport sink (input valid, input target_region, input target_offset,
                input out_data, input port_lines, output ready);
endinterface

`default_nettype wire

/* rtl/bank_switch_memory_decoder.sv */
// Path: a request passes the input register, then the result register, on its way out.
// One request per cycle while the result side does not stall; the port and toggle
// registers update as a request leaves the input register, so the next request
// already decodes against them.
// Reset: asynchronous, active low; port direction and data clear to 0, toggle byte to 0x55,
// both pipeline stages empty.
// ----------------------------------------------------------------------------
// bank_switch_memory_decoder
// Bank switched address decoder with processor port, registered single pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "bank_switch_memory_decoder_macros.svh"

module bank_switch_memory_decoder (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bsmd_req_if.sink   req_i,
  bsmd_rsp_if.source rsp_o
);

  logic               in_valid_q;
  bsmd_pkg::req_t     in_req_q;
  logic               out_valid_q;
  bsmd_pkg::rsp_t     out_rsp_q;
  logic               advance;

  bsmd_pkg::port_state_t port_state;
  bsmd_pkg::port_upd_t   port_upd;
  bsmd_pkg::rsp_t        dec_rsp;

  // request leaves the input stage when the result register is free or drains
  assign advance     = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        in_valid_q <= req_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_req_q.opcode     <= bsmd_pkg::op_e'(req_i.opcode);
      in_req_q.address    <= req_i.address;
      in_req_q.write_data <= req_i.write_data;
    end
    if (advance) begin
      out_rsp_q <= dec_rsp;
    end
  end

  bsmd_decode u_decode (
    .req_i   (in_req_q),
    .state_i (port_state),
    .rsp_o   (dec_rsp),
    .upd_o   (port_upd)
  );

  bsmd_port_regs u_port_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .upd_i   (port_upd),
    .state_o (port_state)
  );

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.target_region = out_rsp_q.target_region;
  assign rsp_o.target_offset = out_rsp_q.target_offset;
  assign rsp_o.out_data      = out_rsp_q.out_data;
  assign rsp_o.port_lines    = out_rsp_q.port_lines;

  `BSMD_ASSERT_NEXT(a_adv_fills_out, advance, out_valid_q, "result register not loaded")
  `BSMD_ASSERT_NEXT(a_toggle_hold, !advance, $stable(port_state.toggle), "toggle byte moved while idle")
  `BSMD_ASSERT_NEXT(a_lines_match, advance, out_rsp_q.port_lines == (~port_state.dir | port_state.data), "port lines disagree with port registers")

endmodule

`default_nettype wire

/* rtl/bsmd_port_regs.sv */
// ----------------------------------------------------------------------------
// bsmd_port_regs
// Processor port direction/data registers and the open-bus toggle byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsmd_port_regs (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire bsmd_pkg::port_upd_t   upd_i,
  output bsmd_pkg::port_state_t      state_o
);

  logic [7:0] dir_q, dir_d;
  logic [7:0] data_q, data_d;
  logic [7:0] toggle_q, toggle_d;

  always_comb begin
    dir_d    = dir_q;
    data_d   = data_q;
    toggle_d = toggle_q;
    if (en_i) begin
      if (upd_i.dir_we) begin
        dir_d = upd_i.wdata;
      end
      if (upd_i.data_we) begin
        data_d = upd_i.wdata;
      end
      if (upd_i.toggle_flip) begin
        toggle_d = ~toggle_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q    <= '0;
      data_q   <= '0;
      toggle_q <= bsmd_pkg::TOGGLE_RESET;
    end else begin
      dir_q    <= dir_d;
      data_q   <= data_d;
      toggle_q <= toggle_d;
    end
  end

  assign state_o.dir    = dir_q;
  assign state_o.data   = data_q;
  assign state_o.toggle = toggle_q;

endmodule

`default_nettype wire

/* rtl/bsmd_decode.sv */
// ----------------------------------------------------------------------------
// bsmd_decode
// Address map decode of one access against the current port lines.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsmd_decode (
  input  wire bsmd_pkg::req_t        req_i,
  input  wire bsmd_pkg::port_state_t state_i,
  output bsmd_pkg::rsp_t             rsp_o,
  output bsmd_pkg::port_upd_t        upd_o
);

  logic [7:0] lines;
  logic       basic_on, kernal_on, char_in, io_in;
  logic       is_wr;
  logic [3:0] bank, io_sel;
  logic [7:0] next_dir, next_data;

  bsmd_pkg::region_e io_region;
  logic [15:0]       io_offset;
  logic [7:0]        io_data;
  logic              io_flip;

  assign lines     = ~state_i.dir | state_i.data;
  assign basic_on  = (lines[1:0] == 2'b11);
  assign kernal_on = lines[1];
  assign char_in   = (lines[1:0] != 2'b00) && !lines[2];
  assign io_in     = (lines[1:0] != 2'b00) && lines[2];
  assign is_wr     = (req_i.opcode == bsmd_pkg::OP_WRITE);
  assign bank      = req_i.address[15:12];
  assign io_sel    = req_i.address[11:8];

  // device decode inside the I/O block
  always_comb begin
    io_flip   = 1'b0;
    io_data   = is_wr ? req_i.write_data : '0;
    io_region = bsmd_pkg::REG_OPENIO;
    io_offset = req_i.address & bsmd_pkg::MASK_4K;
    priority if (io_sel <= bsmd_pkg::SEL_VIC_LAST) begin
      io_region = bsmd_pkg::REG_VIC;
      io_offset = req_i.address & bsmd_pkg::MASK_VIC;
    end else if (io_sel <= bsmd_pkg::SEL_SID_LAST) begin
      io_region = bsmd_pkg::REG_SID;
      io_offset = req_i.address & bsmd_pkg::MASK_SID;
    end else if (io_sel <= bsmd_pkg::SEL_COLOR_LAST) begin
      io_region = bsmd_pkg::REG_COLOR;
      io_offset = req_i.address & bsmd_pkg::MASK_COLOR;
      io_data   = is_wr ? (req_i.write_data & bsmd_pkg::NIBBLE_MASK) : '0;
    end else if (io_sel == bsmd_pkg::SEL_CIA1) begin
      io_region = bsmd_pkg::REG_CIA1;
      io_offset = req_i.address & bsmd_pkg::MASK_CIA;
    end else if (io_sel == bsmd_pkg::SEL_CIA2) begin
      io_region = bsmd_pkg::REG_CIA2;
      io_offset = req_i.address & bsmd_pkg::MASK_CIA;
    end else if (!is_wr && (req_i.address == bsmd_pkg::ADDR_TOGGLE)) begin
      // read of the toggle byte inverts it first
      io_flip   = 1'b1;
      io_region = bsmd_pkg::REG_TOGGLE;
      io_offset = '0;
      io_data   = ~state_i.toggle;
    end else begin
      io_region = bsmd_pkg::REG_OPENIO;
    end
  end

  always_comb begin
    rsp_o.target_region = bsmd_pkg::REG_RAM;
    rsp_o.target_offset = req_i.address;
    rsp_o.out_data      = '0;
    upd_o.dir_we        = 1'b0;
    upd_o.data_we       = 1'b0;
    upd_o.toggle_flip   = 1'b0;
    upd_o.wdata         = req_i.write_data;
    if (is_wr) begin
      rsp_o.out_data = req_i.write_data;
      priority if (req_i.address == bsmd_pkg::ADDR_PORT_DIR) begin
        upd_o.dir_we = 1'b1;
      end else if (req_i.address == bsmd_pkg::ADDR_PORT_DATA) begin
        upd_o.data_we  = 1'b1;
        // RAM shadow of the port data register
        rsp_o.out_data = (state_i.dir & req_i.write_data)
                       | (~state_i.dir & bsmd_pkg::SHADOW_MASK);
      end else if ((bank == bsmd_pkg::BANK_IO) && io_in) begin
        rsp_o.target_region = io_region;
        rsp_o.target_offset = io_offset;
        rsp_o.out_data      = io_data;
      end else begin
        rsp_o.target_region = bsmd_pkg::REG_RAM;
      end
    end else begin
      priority if (((bank == bsmd_pkg::BANK_BASIC_LO) || (bank == bsmd_pkg::BANK_BASIC_HI))
                   && basic_on) begin
        rsp_o.target_region = bsmd_pkg::REG_BASIC;
        rsp_o.target_offset = req_i.address & bsmd_pkg::MASK_ROM8K;
      end else if ((bank == bsmd_pkg::BANK_IO) && io_in) begin
        rsp_o.target_region = io_region;
        rsp_o.target_offset = io_offset;
        rsp_o.out_data      = io_data;
        upd_o.toggle_flip   = io_flip;
      end else if ((bank == bsmd_pkg::BANK_IO) && char_in) begin
        rsp_o.target_region = bsmd_pkg::REG_CHAR;
        rsp_o.target_offset = req_i.address & bsmd_pkg::MASK_4K;
      end else if (((bank == bsmd_pkg::BANK_KERNAL_LO) || (bank == bsmd_pkg::BANK_KERNAL_HI))
                   && kernal_on) begin
        rsp_o.target_region = bsmd_pkg::REG_KERNAL;
        rsp_o.target_offset = req_i.address & bsmd_pkg::MASK_ROM8K;
      end else begin
        rsp_o.target_region = bsmd_pkg::REG_RAM;
      end
    end
    // port lines as they stand after this access
    next_dir         = upd_o.dir_we  ? req_i.write_data : state_i.dir;
    next_data        = upd_o.data_we ? req_i.write_data : state_i.data;
    rsp_o.port_lines = ~next_dir | next_data;
  end

endmodule

`default_nettype wire

/* test/bank_switch_memory_decoder_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bank_switch_memory_decoder_tb
// Drives bus accesses into the decoder and checks every decoded target against
// a typed table entry or a local model of the processor port, bank mapping and
// toggle byte. A short table of corner cases comes first, then random port
// reprogramming mixed with accesses to the switched banks, under three idle
// patterns and two long result stalls.
// ----------------------------------------------------------------------------

module bank_switch_memory_decoder_tb;

  localparam int unsigned LIMIT_CYCLES     = 100000;
  localparam int unsigned RANDOM_PER_PHASE = 484;
  localparam int unsigned HOLD_CYCLES      = 60;
  localparam int unsigned HOLD_FIRST       = 300;
  localparam int unsigned HOLD_SECOND      = 1150;
  localparam int unsigned SETTLE_CYCLES    = 8;
  localparam int unsigned MAX_REPORTS      = 10;

  typedef struct {
    bsmd_pkg::req_t access;
    bit             typed;
    bsmd_pkg::rsp_t typed_rsp;
  } access_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bsmd_req_if req_if ();
  bsmd_rsp_if rsp_if ();

  bank_switch_memory_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Model state of the port and the open-bus toggle byte.
  logic [7:0] cpu_dir;
  logic [7:0] cpu_out;
  logic [7:0] toggle_q;

  bsmd_pkg::rsp_t target_q[$];
  access_row_t    access_table[$];

  bit             row_typed;
  bsmd_pkg::rsp_t row_typed_rsp;
  int unsigned    send_gap_pct;
  int unsigned    recv_idle_pct;
  int unsigned    result_count;
  int unsigned    error_count;
  int unsigned    hold_idx;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void io_target(input bsmd_pkg::req_t a, inout bsmd_pkg::rsp_t o);
    logic [3:0] sel;
    sel = a.address[11:8];
    if (sel <= bsmd_pkg::SEL_VIC_LAST) begin
      o.target_region = bsmd_pkg::REG_VIC;
      o.target_offset = a.address & bsmd_pkg::MASK_VIC;
    end else if (sel <= bsmd_pkg::SEL_SID_LAST) begin
      o.target_region = bsmd_pkg::REG_SID;
      o.target_offset = a.address & bsmd_pkg::MASK_SID;
    end else if (sel <= bsmd_pkg::SEL_COLOR_LAST) begin
      o.target_region = bsmd_pkg::REG_COLOR;
      o.target_offset = a.address & bsmd_pkg::MASK_COLOR;
      if (a.opcode == bsmd_pkg::OP_WRITE) o.out_data = a.write_data & bsmd_pkg::NIBBLE_MASK;
    end else if (sel == bsmd_pkg::SEL_CIA1) begin
      o.target_region = bsmd_pkg::REG_CIA1;
      o.target_offset = a.address & bsmd_pkg::MASK_CIA;
    end else if (sel == bsmd_pkg::SEL_CIA2) begin
      o.target_region = bsmd_pkg::REG_CIA2;
      o.target_offset = a.address & bsmd_pkg::MASK_CIA;
    end else if (a.opcode == bsmd_pkg::OP_READ && a.address == bsmd_pkg::ADDR_TOGGLE) begin
      // open-bus byte flips on every read of the last I/O address while I/O is mapped
      toggle_q        = ~toggle_q;
      o.target_region = bsmd_pkg::REG_TOGGLE;
      o.target_offset = '0;
      o.out_data      = toggle_q;
    end else begin
      o.target_region = bsmd_pkg::REG_OPENIO;
      o.target_offset = a.address & bsmd_pkg::MASK_4K;
    end
  endfunction

  function automatic bsmd_pkg::rsp_t decode_access(input bsmd_pkg::req_t a);
    bsmd_pkg::rsp_t o;
    logic [7:0]     lines;
    logic [3:0]     bank;
    logic           basic_on;
    logic           kernal_on;
    logic           char_in;
    logic           io_in;
    lines     = ~cpu_dir | cpu_out;
    basic_on  = lines[1:0] == 2'b11;
    kernal_on = lines[1];
    char_in   = lines[1:0] != 2'b00 && !lines[2];
    io_in     = lines[1:0] != 2'b00 && lines[2];
    bank      = a.address[15:12];
    o.target_region = bsmd_pkg::REG_RAM;
    o.target_offset = a.address;
    o.out_data      = '0;
    if (a.opcode == bsmd_pkg::OP_WRITE) begin
      o.out_data = a.write_data;
      if (a.address == bsmd_pkg::ADDR_PORT_DIR) begin
        cpu_dir = a.write_data;
      end else if (a.address == bsmd_pkg::ADDR_PORT_DATA) begin
        cpu_out    = a.write_data;
        o.out_data = (cpu_dir & cpu_out) | (~cpu_dir & bsmd_pkg::SHADOW_MASK);
      end else if (bank == bsmd_pkg::BANK_IO && io_in) begin
        io_target(a, o);
      end
    end else begin
      if ((bank == bsmd_pkg::BANK_BASIC_LO || bank == bsmd_pkg::BANK_BASIC_HI)
          && basic_on) begin
        o.target_region = bsmd_pkg::REG_BASIC;
        o.target_offset = a.address & bsmd_pkg::MASK_ROM8K;
      end else if (bank == bsmd_pkg::BANK_IO) begin
        if (io_in) begin
          io_target(a, o);
        end else if (char_in) begin
          o.target_region = bsmd_pkg::REG_CHAR;
          o.target_offset = a.address & bsmd_pkg::MASK_4K;
        end
      end else if ((bank == bsmd_pkg::BANK_KERNAL_LO || bank == bsmd_pkg::BANK_KERNAL_HI)
                   && kernal_on) begin
        o.target_region = bsmd_pkg::REG_KERNAL;
        o.target_offset = a.address & bsmd_pkg::MASK_ROM8K;
      end
    end
    o.port_lines = ~cpu_dir | cpu_out;
    return o;
  endfunction

  function automatic void add_row(input bsmd_pkg::op_e op, input logic [15:0] adr,
                                  input logic [7:0] wd, input bit typed,
                                  input bsmd_pkg::region_e rgn, input logic [15:0] off,
                                  input logic [7:0] dat, input logic [7:0] lines);
    access_row_t row;
    row.access.opcode        = op;
    row.access.address       = adr;
    row.access.write_data    = wd;
    row.typed                = typed;
    row.typed_rsp.target_region = rgn;
    row.typed_rsp.target_offset = off;
    row.typed_rsp.out_data      = dat;
    row.typed_rsp.port_lines    = lines;
    access_table.push_back(row);
  endfunction

  function automatic bsmd_pkg::req_t random_access();
    bsmd_pkg::req_t a;
    a.opcode     = bsmd_pkg::op_e'($urandom_range(1));
    a.write_data = 8'($urandom);
    if ($urandom_range(99) < 15) begin
      // reprogram the port; direction mostly leaves bits 2:0 as outputs
      a.opcode = bsmd_pkg::OP_WRITE;
      if ($urandom_range(3) == 0) begin
        a.address = bsmd_pkg::ADDR_PORT_DIR;
        if ($urandom_range(4) != 0) a.write_data[2:0] = 3'b111;
      end else begin
        a.address = bsmd_pkg::ADDR_PORT_DATA;
      end
    end else begin
      case ($urandom_range(9))
        0: a.address = 16'($urandom);
        1: a.address = {3'b101, 13'($urandom)};
        2: a.address = {3'b111, 13'($urandom)};
        3, 4, 5: a.address = {bsmd_pkg::BANK_IO, 12'($urandom)};
        6: a.address = bsmd_pkg::ADDR_TOGGLE;
        7: a.address = {bsmd_pkg::BANK_IO, 4'($urandom_range(14, 15)), 8'($urandom)};
        8: a.address = 16'($urandom_range(3));
        default: a.address = {bsmd_pkg::BANK_IO, 4'($urandom), {8{1'($urandom)}}};
      endcase
    end
    return a;
  endfunction

  task automatic send_access(input bsmd_pkg::req_t a, input bit typed,
                             input bsmd_pkg::rsp_t typed_rsp);
    while ($urandom_range(99) < send_gap_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.opcode     <= a.opcode;
    req_if.address    <= a.address;
    req_if.write_data <= a.write_data;
    row_typed         <= typed;
    row_typed_rsp     <= typed_rsp;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (target_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    @(posedge clk_i);
    send_gap_pct  = send_pct;
    recv_idle_pct = recv_pct;
    @(negedge clk_i);
  endtask

  // Request capture first, then result check: a result never belongs to a
  // request accepted on the same edge.
  always @(posedge clk_i) begin
    bsmd_pkg::req_t acc;
    bsmd_pkg::rsp_t got;
    bsmd_pkg::rsp_t want;
    if (rst_ni && req_if.valid && req_if.ready) begin
      acc.opcode     = bsmd_pkg::op_e'(req_if.opcode);
      acc.address    = req_if.address;
      acc.write_data = req_if.write_data;
      want = decode_access(acc);
      target_q.push_back(row_typed ? row_typed_rsp : want);
    end
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      result_count++;
      got.target_region = bsmd_pkg::region_e'(rsp_if.target_region);
      got.target_offset = rsp_if.target_offset;
      got.out_data      = rsp_if.out_data;
      got.port_lines    = rsp_if.port_lines;
      if (target_q.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: unexpected result region %0d offset %h data %h lines %h",
                   $time, got.target_region, got.target_offset, got.out_data,
                   got.port_lines);
      end else begin
        want = target_q.pop_front();
        if (got.target_region !== want.target_region ||
            got.target_offset !== want.target_offset ||
            got.out_data !== want.out_data || got.port_lines !== want.port_lines) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: mismatch exp region %0d offset %h data %h lines %h, got %0d %h %h %h",
                     $time, want.target_region, want.target_offset, want.out_data,
                     want.port_lines, got.target_region, got.target_offset,
                     got.out_data, got.port_lines);
        end
      end
    end
  end

  // Result side: random back-pressure plus two long holds that fill the pipe.
  initial begin
    rsp_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if ((hold_idx == 0 && result_count >= HOLD_FIRST) ||
          (hold_idx == 1 && result_count >= HOLD_SECOND)) begin
        hold_idx++;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    bsmd_pkg::rsp_t none;
    none              = '0;
    cpu_dir           = '0;
    cpu_out           = '0;
    toggle_q          = bsmd_pkg::TOGGLE_RESET;
    result_count      = 0;
    error_count       = 0;
    hold_idx          = 0;
    send_gap_pct      = 8;
    recv_idle_pct     = 50;
    row_typed         = 1'b0;
    row_typed_rsp     = '0;
    req_if.valid      = 1'b0;
    req_if.opcode     = bsmd_pkg::OP_READ;
    req_if.address    = '0;
    req_if.write_data = '0;

    // Power-up map: all ROMs and I/O visible, port lines all high.
    add_row(bsmd_pkg::OP_READ, 16'h0000, 8'h00, 1, bsmd_pkg::REG_RAM, 16'h0000, 8'h00, 8'hff);
    add_row(bsmd_pkg::OP_READ, 16'ha000, 8'h00, 1, bsmd_pkg::REG_BASIC, 16'h0000, 8'h00, 8'hff);
    add_row(bsmd_pkg::OP_READ, 16'hffff, 8'h00, 1, bsmd_pkg::REG_KERNAL, 16'h1fff, 8'h00,
            8'hff);
    add_row(bsmd_pkg::OP_READ, 16'hd000, 8'h00, 1, bsmd_pkg::REG_VIC, 16'h0000, 8'h00, 8'hff);
    add_row(bsmd_pkg::OP_READ, 16'hd41f, 8'h00, 1, bsmd_pkg::REG_SID, 16'h001f, 8'h00, 8'hff);
    add_row(bsmd_pkg::OP_READ, 16'hdbff, 8'h00, 1, bsmd_pkg::REG_COLOR, 16'h03ff, 8'h00, 8'hff);
    add_row(bsmd_pkg::OP_READ, 16'hdc0f, 8'h00, 1, bsmd_pkg::REG_CIA1, 16'h000f, 8'h00, 8'hff);
    add_row(bsmd_pkg::OP_READ, 16'hddff, 8'h00, 1, bsmd_pkg::REG_CIA2, 16'h000f, 8'h00, 8'hff);
    add_row(bsmd_pkg::OP_READ, 16'hde00, 8'h00, 1, bsmd_pkg::REG_OPENIO, 16'h0e00, 8'h00,
            8'hff);
    add_row(bsmd_pkg::OP_READ, 16'hdfff, 8'h00, 1, bsmd_pkg::REG_TOGGLE, 16'h0000, 8'haa,
            8'hff);
    add_row(bsmd_pkg::OP_WRITE, 16'hdfff, 8'hff, 1, bsmd_pkg::REG_OPENIO, 16'h0fff, 8'hff,
            8'hff);
    add_row(bsmd_pkg::OP_READ, 16'hdfff, 8'h00, 1, bsmd_pkg::REG_TOGGLE, 16'h0000, 8'h55,
            8'hff);
    add_row(bsmd_pkg::OP_WRITE, 16'hd800, 8'hff, 1, bsmd_pkg::REG_COLOR, 16'h0000, 8'h0f,
            8'hff);
    add_row(bsmd_pkg::OP_WRITE, 16'hd020, 8'h80, 1, bsmd_pkg::REG_VIC, 16'h0020, 8'h80, 8'hff);
    add_row(bsmd_pkg::OP_WRITE, 16'ha000, 8'h00, 1, bsmd_pkg::REG_RAM, 16'ha000, 8'h00, 8'hff);
    add_row(bsmd_pkg::OP_WRITE, 16'hffff, 8'hff, 1, bsmd_pkg::REG_RAM, 16'hffff, 8'hff, 8'hff);
    // shadow of the data register shows the pull-ups on input lines
    add_row(bsmd_pkg::OP_WRITE, bsmd_pkg::ADDR_PORT_DATA, 8'h00, 1, bsmd_pkg::REG_RAM,
            16'h0001, 8'h17, 8'hff);
    add_row(bsmd_pkg::OP_WRITE, bsmd_pkg::ADDR_PORT_DIR, 8'hff, 1, bsmd_pkg::REG_RAM,
            16'h0000, 8'hff, 8'h00);
    add_row(bsmd_pkg::OP_READ, 16'hd000, 8'h00, 1, bsmd_pkg::REG_RAM, 16'hd000, 8'h00, 8'h00);
    add_row(bsmd_pkg::OP_READ, 16'hffff, 8'h00, 1, bsmd_pkg::REG_RAM, 16'hffff, 8'h00, 8'h00);
    add_row(bsmd_pkg::OP_WRITE, bsmd_pkg::ADDR_PORT_DATA, 8'h03, 1, bsmd_pkg::REG_RAM,
            16'h0001, 8'h03, 8'h03);
    add_row(bsmd_pkg::OP_READ, 16'hd000, 8'h00, 0, bsmd_pkg::REG_RAM, 16'h0000, 8'h00, 8'h00);
    add_row(bsmd_pkg::OP_READ, 16'hbfff, 8'h00, 0, bsmd_pkg::REG_RAM, 16'h0000, 8'h00, 8'h00);
    add_row(bsmd_pkg::OP_WRITE, bsmd_pkg::ADDR_PORT_DATA, 8'h06, 0, bsmd_pkg::REG_RAM,
            16'h0000, 8'h00, 8'h00);
    add_row(bsmd_pkg::OP_READ, 16'he123, 8'h00, 0, bsmd_pkg::REG_RAM, 16'h0000, 8'h00, 8'h00);
    add_row(bsmd_pkg::OP_READ, 16'hdfff, 8'h00, 0, bsmd_pkg::REG_RAM, 16'h0000, 8'h00, 8'h00);
    add_row(bsmd_pkg::OP_WRITE, bsmd_pkg::ADDR_PORT_DATA, 8'h05, 0, bsmd_pkg::REG_RAM,
            16'h0000, 8'h00, 8'h00);
    add_row(bsmd_pkg::OP_WRITE, 16'hd4ff, 8'h5a, 0, bsmd_pkg::REG_RAM, 16'h0000, 8'h00, 8'h00);
    add_row(bsmd_pkg::OP_WRITE, bsmd_pkg::ADDR_PORT_DIR, 8'h00, 0, bsmd_pkg::REG_RAM,
            16'h0000, 8'h00, 8'h00);

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < access_table.size(); i++)
      send_access(access_table[i].access, access_table[i].typed, access_table[i].typed_rsp);

    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) set_idling(50, 8);
      if (phase == 2) set_idling(0, 0);
      for (int n = 0; n < RANDOM_PER_PHASE; n++)
        send_access(random_access(), 1'b0, none);
      // sender pause until the pipe has emptied
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0 && target_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/bsmd_pkg.sv
rtl/bsmd_req_if.sv
rtl/bsmd_rsp_if.sv
rtl/bsmd_port_regs.sv
rtl/bsmd_decode.sv
rtl/bank_switch_memory_decoder.sv
test/bank_switch_memory_decoder_tb.sv
